// ===== sv/lru_block_cache_tags_defines.svh =====
// Assertion helpers shared by the cache tag blocks.
// Every check is clocked on clk_i and switched off while rst_ni is low.
`ifndef LRU_BLOCK_CACHE_TAGS_DEFINES_SVH
`define LRU_BLOCK_CACHE_TAGS_DEFINES_SVH

`define LBCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define LBCT_ASSERT_NEVER(lbl, cond, msg) \
  `LBCT_ASSERT(lbl, !(cond), msg)

`endif

// ===== sv/lbct_pkg.sv =====
package lbct_pkg;

  localparam int unsigned ENTRIES       = 16;
  localparam int unsigned DISK_BLK_BITS = 23;
  localparam int unsigned SLOT_W        = $clog2(ENTRIES);
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam int unsigned PTR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W         = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_FLUSH = 2'd2;

  typedef logic [SLOT_W-1:0]        slot_t;
  typedef logic [DISK_BLK_BITS-1:0] disk_blk_t;

  localparam slot_t RANK_MAX = slot_t'(ENTRIES - 1);

  typedef enum logic [1:0] {
    OP_READ,
    OP_WRITE,
    OP_FLUSH
  } op_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_LOOKUP,
    B_UPDATE,
    B_FLUSH
  } back_state_e;

  typedef struct packed {
    logic [1:0] cmd;
    disk_blk_t  disk_blk;
  } req_t;

  typedef struct packed {
    slot_t     slot;
    logic      hit;
    logic      writeback_valid;
    disk_blk_t writeback_block;
    slot_t     writeback_slot;
    logic      last;
  } rsp_t;

  typedef struct packed {
    op_e       op;
    disk_blk_t disk_blk;
  } job_t;

endpackage

// ===== sv/lbct_front.sv =====
`include "lru_block_cache_tags_defines.svh"

module lbct_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  lbct_pkg::req_t    req_i,
  input  logic              pop_i,
  output logic              head_valid_o,
  output lbct_pkg::job_t    head_o
);

  lbct_pkg::job_t                   mem_q [lbct_pkg::QUEUE_DEPTH];
  logic [lbct_pkg::PTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [lbct_pkg::PTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [lbct_pkg::CNT_W-1:0]       count_q, count_d;
  logic                             keep;
  logic                             push;
  lbct_pkg::job_t                   job;

  // Decode the command; the unused code is taken and then dropped.
  always_comb begin
    keep         = 1'b1;
    job.op       = lbct_pkg::OP_READ;
    job.disk_blk = req_i.disk_blk;
    case (req_i.cmd)
      lbct_pkg::CMD_READ:  job.op = lbct_pkg::OP_READ;
      lbct_pkg::CMD_WRITE: job.op = lbct_pkg::OP_WRITE;
      lbct_pkg::CMD_FLUSH: job.op = lbct_pkg::OP_FLUSH;
      default:             keep   = 1'b0;
    endcase
  end

  assign busy         = (count_q == lbct_pkg::CNT_W'(lbct_pkg::QUEUE_DEPTH));
  assign push         = start && !busy && keep;
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == lbct_pkg::PTR_W'(lbct_pkg::QUEUE_DEPTH - 1)) ? '0 :
                 wr_ptr_q + lbct_pkg::PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == lbct_pkg::PTR_W'(lbct_pkg::QUEUE_DEPTH - 1)) ? '0 :
                 rd_ptr_q + lbct_pkg::PTR_W'(1);
    end
    case ({push, pop_i})
      2'b10:   count_d = count_q + lbct_pkg::CNT_W'(1);
      2'b01:   count_d = count_q - lbct_pkg::CNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= job;
    end
  end

  // The back end may only take an entry that is there.
  `LBCT_ASSERT_NEVER(a_pop_empty, pop_i && (count_q == '0), "pop from empty queue")

endmodule

// ===== sv/lbct_back.sv =====
`include "lru_block_cache_tags_defines.svh"

module lbct_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  lbct_pkg::job_t    head_i,
  output logic              pop_o,
  output logic              rsp_valid_o,
  output lbct_pkg::rsp_t    rsp_o
);

  lbct_pkg::back_state_e         state_q, state_d, state_next_job;
  lbct_pkg::job_t                job_q;
  logic [lbct_pkg::ENTRIES-1:0]  slot_valid_q;
  logic [lbct_pkg::ENTRIES-1:0]  slot_dirty_q;
  lbct_pkg::slot_t               recency_rank_q [lbct_pkg::ENTRIES];
  lbct_pkg::disk_blk_t           slot_tag_q [lbct_pkg::ENTRIES];

  lbct_pkg::slot_t               sel_q;
  lbct_pkg::slot_t               limit_q;
  logic                          hit_q;
  logic                          evict_q;

  logic [lbct_pkg::ENTRIES-1:0]  hit_vec, free_vec, old_vec, flush_mask;
  lbct_pkg::slot_t               hit_idx, free_idx, old_idx, flush_idx, sel_d, rd_idx;
  lbct_pkg::disk_blk_t           rd_tag;
  logic                          flush_last;
  logic                          lookup_en, update_en, flush_clear, emit_d;
  logic                          is_write, wb_needed;
  lbct_pkg::rsp_t                rsp_d, rsp_q;
  logic                          rsp_valid_q;

  function automatic lbct_pkg::slot_t lowest_set(input logic [lbct_pkg::ENTRIES-1:0] v);
    lbct_pkg::slot_t idx;
    idx = '0;
    for (int i = lbct_pkg::ENTRIES - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = lbct_pkg::slot_t'(i);
      end
    end
    return idx;
  endfunction

  // Tag compare, free search and victim search over all slots in parallel.
  always_comb begin
    for (int i = 0; i < lbct_pkg::ENTRIES; i++) begin
      hit_vec[i]  = slot_valid_q[i] && (slot_tag_q[i] == job_q.disk_blk);
      free_vec[i] = !slot_valid_q[i];
      // Valid ranks are distinct, so in a full cache exactly one slot is the oldest.
      old_vec[i]  = (recency_rank_q[i] == lbct_pkg::RANK_MAX);
    end
    hit_idx  = lowest_set(hit_vec);
    free_idx = lowest_set(free_vec);
    old_idx  = lowest_set(old_vec);
    if (|hit_vec) begin
      sel_d = hit_idx;
    end else if (|free_vec) begin
      sel_d = free_idx;
    end else begin
      sel_d = old_idx;
    end
  end

  assign flush_mask = slot_valid_q & slot_dirty_q;
  assign flush_idx  = lowest_set(flush_mask);
  assign flush_last = ((flush_mask & (flush_mask - lbct_pkg::ENTRIES'(1))) == '0);
  assign rd_idx     = (state_q == lbct_pkg::B_FLUSH) ? flush_idx : sel_q;
  assign rd_tag     = slot_tag_q[rd_idx];
  assign is_write   = (job_q.op == lbct_pkg::OP_WRITE);
  assign wb_needed  = evict_q && slot_dirty_q[sel_q];

  assign state_next_job = (head_i.op == lbct_pkg::OP_FLUSH) ? lbct_pkg::B_FLUSH :
                          lbct_pkg::B_LOOKUP;

  always_comb begin
    state_d     = state_q;
    pop_o       = 1'b0;
    lookup_en   = 1'b0;
    update_en   = 1'b0;
    flush_clear = 1'b0;
    emit_d      = 1'b0;
    rsp_d       = '0;
    case (state_q)
      lbct_pkg::B_IDLE: begin
        if (head_valid_i) begin
          pop_o   = 1'b1;
          state_d = state_next_job;
        end
      end
      lbct_pkg::B_LOOKUP: begin
        lookup_en = 1'b1;
        state_d   = lbct_pkg::B_UPDATE;
      end
      lbct_pkg::B_UPDATE: begin
        update_en             = 1'b1;
        emit_d                = 1'b1;
        rsp_d.slot            = sel_q;
        rsp_d.hit             = hit_q;
        rsp_d.writeback_valid = wb_needed;
        rsp_d.writeback_block = wb_needed ? rd_tag : '0;
        rsp_d.writeback_slot  = wb_needed ? sel_q : '0;
        rsp_d.last            = 1'b1;
        if (head_valid_i) begin
          pop_o   = 1'b1;
          state_d = state_next_job;
        end else begin
          state_d = lbct_pkg::B_IDLE;
        end
      end
      lbct_pkg::B_FLUSH: begin
        emit_d = 1'b1;
        // An empty mask can only be seen on the first cycle of a flush.
        if (flush_mask != '0) begin
          flush_clear           = 1'b1;
          rsp_d.writeback_valid = 1'b1;
          rsp_d.writeback_block = rd_tag;
          rsp_d.writeback_slot  = flush_idx;
        end
        rsp_d.last = flush_last;
        if (flush_last) begin
          if (head_valid_i) begin
            pop_o   = 1'b1;
            state_d = state_next_job;
          end else begin
            state_d = lbct_pkg::B_IDLE;
          end
        end
      end
      default: begin
        state_d = lbct_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lbct_pkg::B_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= emit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= head_i;
    end
    if (emit_d) begin
      rsp_q <= rsp_d;
    end
    if (lookup_en) begin
      sel_q   <= sel_d;
      hit_q   <= |hit_vec;
      evict_q <= !(|hit_vec) && !(|free_vec);
      // On a miss into a free slot every valid slot ages.
      limit_q <= (!(|hit_vec) && (|free_vec)) ? lbct_pkg::RANK_MAX : recency_rank_q[sel_d];
    end
    if (update_en && !hit_q) begin
      slot_tag_q[sel_q] <= job_q.disk_blk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
      slot_dirty_q <= '0;
      for (int i = 0; i < lbct_pkg::ENTRIES; i++) begin
        recency_rank_q[i] <= '0;
      end
    end else if (update_en) begin
      slot_valid_q[sel_q] <= 1'b1;
      slot_dirty_q[sel_q] <= (hit_q && slot_dirty_q[sel_q]) || is_write;
      for (int i = 0; i < lbct_pkg::ENTRIES; i++) begin
        if (lbct_pkg::slot_t'(i) == sel_q) begin
          recency_rank_q[i] <= '0;
        end else if (slot_valid_q[i] && (recency_rank_q[i] < limit_q)) begin
          recency_rank_q[i] <= recency_rank_q[i] + lbct_pkg::slot_t'(1);
        end
      end
    end else if (flush_clear) begin
      slot_dirty_q[flush_idx] <= 1'b0;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  `LBCT_ASSERT(a_update_mru, (state_q == lbct_pkg::B_UPDATE) |=> (slot_valid_q[$past(sel_q)] && (recency_rank_q[$past(sel_q)] == '0)), "updated slot is not valid and most recent")
  `LBCT_ASSERT(a_flush_clean, (state_q == lbct_pkg::B_FLUSH) && rsp_d.writeback_valid |=> !slot_dirty_q[$past(rsp_d.writeback_slot)], "flushed slot still dirty")
  `LBCT_ASSERT_NEVER(a_dirty_valid, (slot_dirty_q & ~slot_valid_q) != '0, "dirty bit on an invalid slot")

endmodule

// ===== sv/lru_block_cache_tags.sv =====
// A read or write access passes the queue, then the back end's lookup and update states.
// Its result is registered; the next queued access is taken in the update state.
// A flush gives one result per cycle: one per dirty slot, or one if no slot is dirty.
// A two-entry command queue lets new commands in while the back end works; busy means it is full.
// Reset empties the queue and leaves every slot invalid, clean and of rank zero.
module lru_block_cache_tags (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  lbct_pkg::req_t    req_i,
  output logic              rsp_valid_o,
  output lbct_pkg::rsp_t    rsp_o
);

  logic              head_valid;
  logic              pop;
  lbct_pkg::job_t    head;

  lbct_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .req_i        (req_i),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  lbct_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .rsp_valid_o  (rsp_valid_o),
    .rsp_o        (rsp_o)
  );

endmodule
